// ===== rtl/xtea_rk_pkg.sv =====
// Package for the rolling-key XTEA encryptor: widths, codes, state type.
// Depends on nothing; every other file in rtl/ imports it.
package xtea_rk_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_KEYS  = 4;
  localparam int unsigned KEY_IDX_W = 2;

  localparam logic [WORD_W-1:0] XTEA_DELTA = 32'h9E3779B9;

  typedef logic [WORD_W-1:0] word_t;

  // Operation carried by the op field of an input transaction.
  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_RELOAD  = 1'b1
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY0 = 3'd0,
    CFG_KEY1 = 3'd1,
    CFG_KEY2 = 3'd2,
    CFG_KEY3 = 3'd3,
    CFG_POLY = 3'd4
  } cfg_idx_t;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  // Control from the sequencer to the key store.
  typedef struct packed {
    logic reload;
    logic roll;
  } key_ctrl_t;

endpackage

// ===== rtl/xtea_rk_if.sv =====
// Valid/ready channel interfaces for input, result and configuration.
// Depends on xtea_rk_pkg for field widths.
interface xtea_rk_in_if;
  import xtea_rk_pkg::*;
  logic  valid;
  logic  ready;
  logic  op;
  word_t plain_low;
  word_t plain_high;
  modport source (output valid, output op, output plain_low, output plain_high, input ready);
  modport sink (input valid, input op, input plain_low, input plain_high, output ready);
endinterface

interface xtea_rk_out_if;
  import xtea_rk_pkg::*;
  logic  valid;
  logic  ready;
  word_t cipher_low;
  word_t cipher_high;
  modport source (output valid, output cipher_low, output cipher_high, input ready);
  modport sink (input valid, input cipher_low, input cipher_high, output ready);
endinterface

interface xtea_rk_cfg_if;
  import xtea_rk_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  word_t                data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/xtea_rk_half.sv =====
// Shared XTEA half-round unit: one Feistel update of one 32-bit half.
// Depends on xtea_rk_pkg.
module xtea_rk_half (
  input  xtea_rk_pkg::word_t v_acc,
  input  xtea_rk_pkg::word_t v_src,
  input  xtea_rk_pkg::word_t sum,
  input  xtea_rk_pkg::word_t key,
  output xtea_rk_pkg::word_t v_new
);
  import xtea_rk_pkg::*;

  word_t mix;
  word_t sum_key;

  // Mix the other half, add the round key, fold into this half.
  assign mix     = ((v_src << 4) ^ (v_src >> 5)) + v_src;
  assign sum_key = sum + key;
  assign v_new   = v_acc + (mix ^ sum_key);

endmodule

// ===== rtl/xtea_rk_keys.sv =====
// Key store: configured key words, roll polynomial and the active keys.
// Depends on xtea_rk_pkg.
module xtea_rk_keys (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [xtea_rk_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  xtea_rk_pkg::word_t                   cfg_data,
  input  xtea_rk_pkg::key_ctrl_t               ctrl,
  input  xtea_rk_pkg::word_t                   roll_first,
  input  logic [xtea_rk_pkg::KEY_IDX_W-1:0]    rd_idx,
  output xtea_rk_pkg::word_t                   rd_key
);
  import xtea_rk_pkg::*;

  word_t key_word_r [NUM_KEYS];
  word_t poly_r;
  word_t active_r   [NUM_KEYS];
  word_t rolled     [NUM_KEYS];

  // One LFSR step per active key word.
  always_comb begin
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (active_r[i][WORD_W-1]) begin
        rolled[i] = ((active_r[i] ^ poly_r) << 1) | word_t'(1);
      end else begin
        rolled[i] = active_r[i] << 1;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        key_word_r[i] <= '0;
      end
      poly_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_KEY0: key_word_r[0] <= cfg_data;
        CFG_KEY1: key_word_r[1] <= cfg_data;
        CFG_KEY2: key_word_r[2] <= cfg_data;
        CFG_KEY3: key_word_r[3] <= cfg_data;
        CFG_POLY: poly_r        <= cfg_data;
        default:  ;
      endcase
    end
  end

  // Active keys: cleared by a key write, loaded by reload, rolled after a block.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        active_r[i] <= '0;
      end
    end else begin
      priority if (cfg_we && cfg_idx < CFG_IDX_W'(NUM_KEYS)) begin
        for (int i = 0; i < NUM_KEYS; i++) begin
          active_r[i] <= '0;
        end
      end else if (ctrl.reload) begin
        for (int i = 0; i < NUM_KEYS; i++) begin
          active_r[i] <= key_word_r[i];
        end
      end else if (ctrl.roll) begin
        active_r[0] <= rolled[0] ^ roll_first;
        for (int i = 1; i < NUM_KEYS; i++) begin
          active_r[i] <= rolled[i];
        end
      end else begin
        // Otherwise the active keys hold.
        for (int i = 0; i < NUM_KEYS; i++) begin
          active_r[i] <= active_r[i];
        end
      end
    end
  end

  assign rd_key = active_r[rd_idx];

endmodule

// ===== rtl/xtea_rolling_key_encrypt.sv =====
// XTEA encryptor with rolling keys. One half-round per cycle in a shared unit,
// but the last half-round of a block waits while an old result is not taken.
// A block takes no new transaction while it runs; the input is ready again in
// the same cycle as the result appears. A reload loads the active keys and stays idle.
// Reset clears the sequencer, the result valid flag, the configuration
// registers and the active keys.
module xtea_rolling_key_encrypt #(
  parameter int unsigned ROUNDS = 32
) (
  input logic          clk,
  input logic          rst_n,
  xtea_rk_in_if.sink   in_ch,
  xtea_rk_out_if.source out_ch,
  xtea_rk_cfg_if.sink  cfg_ch
);
  import xtea_rk_pkg::*;

  localparam int unsigned STEPS = 2 * ROUNDS;
  localparam int unsigned CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] step_r, step_nxt;
  word_t            v0_r, v0_nxt;
  word_t            v1_r, v1_nxt;
  word_t            sum_r, sum_nxt;
  word_t            first_r, first_nxt;
  word_t            cipher_low_r, cipher_low_nxt;
  word_t            cipher_high_r, cipher_high_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic                 phase;
  logic                 commit;
  logic                 in_take;
  key_ctrl_t            key_ctrl;
  logic [KEY_IDX_W-1:0] key_idx;
  word_t                key;
  word_t                half_acc;
  word_t                half_src;
  word_t                half_out;

  // Configuration is always taken.
  assign cfg_ch.ready = 1'b1;

  // Even steps update v0, odd steps update v1.
  assign phase    = step_r[0];
  assign key_idx  = phase ? sum_r[12:11] : sum_r[KEY_IDX_W-1:0];
  assign half_acc = phase ? v1_r : v0_r;
  assign half_src = phase ? v0_r : v1_r;

  xtea_rk_keys u_keys (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_ch.valid),
    .cfg_idx    (cfg_ch.index),
    .cfg_data   (cfg_ch.data),
    .ctrl       (key_ctrl),
    .roll_first (first_r),
    .rd_idx     (key_idx),
    .rd_key     (key)
  );

  xtea_rk_half u_half (
    .v_acc (half_acc),
    .v_src (half_src),
    .sum   (sum_r),
    .key   (key),
    .v_new (half_out)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign commit      = (state_r == ST_RUN) && (step_r == LAST_STEP) &&
                       (!out_valid_r || out_ch.ready);

  // Sequencer: next state and datapath controls.
  always_comb begin
    state_nxt       = state_r;
    step_nxt        = step_r;
    v0_nxt          = v0_r;
    v1_nxt          = v1_r;
    sum_nxt         = sum_r;
    first_nxt       = first_r;
    cipher_low_nxt  = cipher_low_r;
    cipher_high_nxt = cipher_high_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    key_ctrl        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          if (op_t'(in_ch.op) == OP_RELOAD) begin
            key_ctrl.reload = 1'b1;
          end else begin
            v0_nxt    = in_ch.plain_low;
            v1_nxt    = in_ch.plain_high;
            first_nxt = in_ch.plain_low;
            sum_nxt   = '0;
            step_nxt  = '0;
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (step_r != LAST_STEP) begin
          step_nxt = step_r + CNT_W'(1);
          if (phase) begin
            v1_nxt = half_out;
          end else begin
            v0_nxt  = half_out;
            sum_nxt = sum_r + XTEA_DELTA;
          end
        end else if (commit) begin
          v1_nxt          = half_out;
          cipher_low_nxt  = v0_r;
          cipher_high_nxt = half_out;
          out_valid_nxt   = 1'b1;
          key_ctrl.roll   = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    v0_r          <= v0_nxt;
    v1_r          <= v1_nxt;
    sum_r         <= sum_nxt;
    first_r       <= first_nxt;
    cipher_low_r  <= cipher_low_nxt;
    cipher_high_r <= cipher_high_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.cipher_low  = cipher_low_r;
  assign out_ch.cipher_high = cipher_high_r;

  // A result appears only as the last half-round of a block commits.
  a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RUN) && $past(step_r == LAST_STEP))
    else $error("result raised outside the final half-round");

  // The step counter never passes the final half-round.
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= LAST_STEP)
    else $error("half-round counter out of range");

  // An encrypt transaction starts the rounds from step zero with a cleared sum.
  a_encrypt_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && in_ch.op == OP_ENCRYPT |=> state_r == ST_RUN && step_r == '0 && sum_r == '0)
    else $error("encrypt did not start a fresh block");

  // A reload transaction leaves the block idle and gives no result.
  a_reload_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && in_ch.op == OP_RELOAD |=> state_r == ST_IDLE && !$rose(out_valid_r))
    else $error("reload started a block or gave a result");

endmodule
